>>> src/uri_dot_segment_remover_defines.svh
// Assertion macros for the URI dot-segment remover.
// Depends on nothing; expects clk and rst in the scope of use.
`ifndef URI_DOT_SEGMENT_REMOVER_DEFINES_SVH
`define URI_DOT_SEGMENT_REMOVER_DEFINES_SVH

`ifndef ASSERT_OFF
`define UDSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UDSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UDSR_ASSERT(lbl, prop, msg)
`define UDSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/udsr_pkg.sv
// Package for the URI dot-segment remover: default sizes, character codes,
// command and dot-state codes. Depends on nothing.
package udsr_pkg;

  localparam int MAX_PATH_DEF = 512;
  localparam int MAX_SEG_DEF  = 256;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // dot state of the open segment
  localparam logic [1:0] DOTS_NONE = 2'd0;
  localparam logic [1:0] DOTS_ONE  = 2'd1;
  localparam logic [1:0] DOTS_TWO  = 2'd2;
  localparam logic [1:0] DOTS_ORD  = 2'd3;

endpackage

>>> src/uri_dot_segment_remover.sv
// Streaming RFC 3986 dot-segment removal; path store and segment stack in RAM.
// Results are registered in the output stage with the path store read; a stalled
// output parks one in a skid register. Throughput: one item per cycle while the skid
// is empty, set by the single path store write port and the stack top prefetch (one
// stack read per cycle at count-2). Reset (rst, synchronous): clears length, stack count,
// dot state and flags; the path store and the stack RAM are not cleared. Depends on udsr_pkg.
`include "uri_dot_segment_remover_defines.svh"

module uri_dot_segment_remover
  import udsr_pkg::*;
#(
  parameter int MAX_PATH     = MAX_PATH_DEF,
  parameter int MAX_SEGMENTS = MAX_SEG_DEF,
  localparam int PA_W  = $clog2(MAX_PATH),
  localparam int LEN_W = $clog2(MAX_PATH + 1),
  localparam int SA_W  = $clog2(MAX_SEGMENTS),
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [7:0]       char_in,
  input  logic             last,
  input  logic [PA_W-1:0]  read_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic [LEN_W-1:0] out_length,
  output logic             finished,
  output logic             overflowed
);

  typedef struct packed {
    logic             hit;
    logic [PA_W-1:0]  idx;
    logic [LEN_W-1:0] length;
    logic             done;
    logic             ovf;
  } res_t;

  logic [7:0]       path_mem  [MAX_PATH];
  logic [LEN_W-1:0] stack_mem [MAX_SEGMENTS];

  logic [LEN_W-1:0] path_len, path_len_next;
  logic [CNT_W-1:0] seg_cnt, seg_cnt_next;
  logic [LEN_W-1:0] pend_start, pend_start_next;
  logic [1:0]       pend_dots, pend_dots_next;
  logic             after_slash, after_slash_next;
  logic             done_flag, done_flag_next;
  logic             ovf_flag, ovf_flag_next;

  logic [LEN_W-1:0] top_reg;
  logic             pop_prev;
  logic [LEN_W-1:0] stack_rd;
  logic [LEN_W-1:0] top_eff;
  logic [CNT_W-1:0] cnt_m2;
  logic [7:0]       path_rd;

  logic             accept, feed, push, pop;
  logic             do_pop, open, open_slash, tail;
  logic [LEN_W-1:0] base, cut_len;
  logic [1:0]       dots_new;
  logic             wr_en;
  logic [PA_W-1:0]  wr_addr;
  logic [7:0]       wr_data;

  logic             p_valid, k_valid, advance, load_p;
  res_t             p_rec, k_rec, in_rec, src_rec;

  assign in_ready = !k_valid;
  assign accept   = in_valid && in_ready;
  assign feed     = accept && (cmd == CMD_FEED) && !done_flag;
  assign top_eff  = pop_prev ? stack_rd : top_reg;
  assign cnt_m2   = seg_cnt - CNT_W'(2);

  always_comb begin
    path_len_next    = path_len;
    seg_cnt_next     = seg_cnt;
    pend_start_next  = pend_start;
    pend_dots_next   = pend_dots;
    after_slash_next = after_slash;
    done_flag_next   = done_flag;
    ovf_flag_next    = ovf_flag;
    push       = 1'b0;
    do_pop     = 1'b0;
    open       = 1'b0;
    open_slash = 1'b0;
    tail       = 1'b0;
    base       = path_len;
    dots_new   = pend_dots;
    wr_en      = 1'b0;
    wr_addr    = path_len[PA_W-1:0];
    wr_data    = char_in;

    if (feed) begin
      if (last) begin
        done_flag_next = 1'b1;
      end
      if (!ovf_flag) begin
        if (char_in == CH_SLASH) begin
          if (pend_dots == DOTS_ONE || pend_dots == DOTS_TWO) begin
            base       = pend_start;
            do_pop     = (pend_dots == DOTS_TWO) && after_slash;
            open       = 1'b1;
            open_slash = after_slash;
          end else if (pend_dots == DOTS_NONE && !after_slash) begin
            open       = 1'b1;
            open_slash = 1'b1;
          end else if (seg_cnt >= CNT_W'(MAX_SEGMENTS)) begin
            ovf_flag_next = 1'b1;
            path_len_next = pend_start;
          end else begin
            push       = 1'b1;
            open       = 1'b1;
            open_slash = 1'b1;
          end
        end else begin
          if (char_in == CH_DOT) begin
            dots_new = (pend_dots == DOTS_ORD) ? DOTS_ORD : pend_dots + 2'd1;
          end else begin
            dots_new = DOTS_ORD;
          end
          pend_dots_next = dots_new;
          if (path_len >= LEN_W'(MAX_PATH)) begin
            ovf_flag_next = 1'b1;
          end else begin
            wr_en         = 1'b1;
            path_len_next = path_len + LEN_W'(1);
            if (last && (dots_new == DOTS_ONE || dots_new == DOTS_TWO)) begin
              base   = pend_start;
              do_pop = (dots_new == DOTS_TWO) && after_slash;
              tail   = 1'b1;
            end
          end
        end
      end
    end

    pop = do_pop && (seg_cnt != '0);
    if (pop) begin
      seg_cnt_next = seg_cnt - CNT_W'(1);
    end
    if (push) begin
      seg_cnt_next = seg_cnt + CNT_W'(1);
    end
    cut_len = do_pop ? (pop ? top_eff : '0) : base;

    // open a segment, or close a final dot segment, at cut_len
    if (open || tail) begin
      path_len_next = cut_len;
      if (open) begin
        pend_start_next  = cut_len;
        pend_dots_next   = DOTS_NONE;
        after_slash_next = open_slash;
      end
      if ((open && open_slash) || (tail && after_slash)) begin
        if (cut_len >= LEN_W'(MAX_PATH)) begin
          ovf_flag_next = 1'b1;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = cut_len[PA_W-1:0];
          wr_data       = CH_SLASH;
          path_len_next = cut_len + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_len    <= '0;
      seg_cnt     <= '0;
      pend_start  <= '0;
      pend_dots   <= DOTS_NONE;
      after_slash <= 1'b0;
      done_flag   <= 1'b0;
      ovf_flag    <= 1'b0;
      pop_prev    <= 1'b0;
    end else begin
      path_len    <= path_len_next;
      seg_cnt     <= seg_cnt_next;
      pend_start  <= pend_start_next;
      pend_dots   <= pend_dots_next;
      after_slash <= after_slash_next;
      done_flag   <= done_flag_next;
      ovf_flag    <= ovf_flag_next;
      pop_prev    <= pop;
    end
  end

  // top of stack cache; after a pop the prefetched entry takes over
  always_ff @(posedge clk) begin
    top_reg <= push ? pend_start : top_eff;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[seg_cnt[SA_W-1:0]] <= pend_start;
    end
    stack_rd <= stack_mem[cnt_m2[SA_W-1:0]];
  end

  // result records
  always_comb begin
    in_rec.hit    = (cmd == CMD_READ) && (LEN_W'(read_index) < path_len);
    in_rec.idx    = read_index;
    in_rec.length = path_len_next;
    in_rec.done   = done_flag_next;
    in_rec.ovf    = ovf_flag_next;
  end

  assign advance = !p_valid || out_ready;
  assign src_rec = k_valid ? k_rec : in_rec;
  assign load_p  = advance && (k_valid || accept);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      path_mem[wr_addr] <= wr_data;
    end
    if (load_p && src_rec.hit) begin
      path_rd <= path_mem[src_rec.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      k_valid <= 1'b0;
    end else begin
      if (advance) begin
        p_valid <= k_valid || accept;
        k_valid <= 1'b0;
      end else if (accept) begin
        k_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_p) begin
      p_rec <= src_rec;
    end
    if (!advance && accept) begin
      k_rec <= in_rec;
    end
  end

  assign out_valid  = p_valid;
  assign out_char   = p_rec.hit ? path_rd : 8'd0;
  assign out_length = p_rec.length;
  assign finished   = p_rec.done;
  assign overflowed = p_rec.ovf;

  `UDSR_ASSERT(a_skid_behind_out, k_valid |-> p_valid, "skid full with output empty")
  `UDSR_ASSERT(a_len_bound, path_len <= LEN_W'(MAX_PATH), "path length beyond store size")
  `UDSR_ASSERT(a_cnt_bound, seg_cnt <= CNT_W'(MAX_SEGMENTS), "segment count beyond stack")
  `UDSR_ASSERT(a_done_sticky, done_flag |=> done_flag, "done flag dropped without reset")
  `UDSR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

endmodule

>>> verif/tb_uri_dot_segment_remover.sv
// Testbench for uri_dot_segment_remover: drives one long URI path with reads mixed in,
// predicts every result with a local dot-segment model, checks each field in order.
// Depends on udsr_pkg and the block's RTL.
module tb_uri_dot_segment_remover;
  timeunit 1ns;
  timeprecision 1ps;
  import udsr_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       last;
    logic [8:0] idx;
  } path_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [9:0] len;
    logic       fin;
    logic       ovf;
  } path_status_t;

  typedef enum int {SEG_WORD, SEG_DOT, SEG_DOTDOT, SEG_EMPTY} seg_kind_t;
  typedef enum int {END_DOT, END_STORE_FULL, END_STACK_FULL} end_kind_t;
  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  localparam int PLAN = 0;
  localparam int LIVE = 1;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       cmd = CMD_FEED;
  logic [7:0] char_in = 8'h00;
  logic       last = 1'b0;
  logic [8:0] read_index = 9'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic [9:0] out_length;
  logic       finished;
  logic       overflowed;

  uri_dot_segment_remover i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .char_in(char_in),
    .last(last),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .out_length(out_length),
    .finished(finished),
    .overflowed(overflowed)
  );

  always #2 clk = ~clk;

  // two copies of the normalizer state: one for planning stimulus, one for checking
  logic [7:0] path_mem  [2][MAX_PATH_DEF];
  logic [9:0] seg_base  [2][MAX_SEG_DEF];
  logic [9:0] path_len  [2];
  logic [8:0] seg_cnt   [2];
  logic [9:0] open_base [2];
  logic [1:0] dot_state [2];
  logic       slash_led [2];
  logic       fin_flag  [2];
  logic       ovf_flag  [2];
  int         high_mark [2];

  path_item_t   path_items[$];
  path_status_t expected_status[$];
  path_status_t want_status;
  path_item_t   fed_item;
  int           n_in = 0;
  int           n_out = 0;
  int           n_planned = 0;
  int           n_errors = 0;
  bit           moved = 1'b0;
  bit           hold_rx = 1'b0;

  function automatic void append_char(int s, logic [7:0] c);
    if (path_len[s] >= MAX_PATH_DEF) begin
      ovf_flag[s] = 1'b1;
    end else begin
      path_mem[s][path_len[s]] = c;
      path_len[s] = path_len[s] + 1'b1;
    end
  endfunction

  function automatic void drop_segment(int s);
    if (seg_cnt[s] > 0) begin
      seg_cnt[s] = seg_cnt[s] - 1'b1;
      path_len[s] = seg_base[s][seg_cnt[s]];
    end else begin
      path_len[s] = 10'd0;
    end
  endfunction

  function automatic void start_segment(int s, logic slash);
    open_base[s] = path_len[s];
    dot_state[s] = DOTS_NONE;
    slash_led[s] = slash;
    if (slash) append_char(s, CH_SLASH);
  endfunction

  function automatic void take_path_char(int s, logic [7:0] c, logic fin);
    if (c == CH_SLASH) begin
      if (dot_state[s] == DOTS_ONE || dot_state[s] == DOTS_TWO) begin
        path_len[s] = open_base[s];
        if (dot_state[s] == DOTS_TWO && slash_led[s]) drop_segment(s);
        if (!slash_led[s]) begin
          start_segment(s, 1'b0);
          return;
        end
      end else if (dot_state[s] != DOTS_NONE || slash_led[s]) begin
        if (seg_cnt[s] >= MAX_SEG_DEF) begin
          ovf_flag[s] = 1'b1;
          path_len[s] = open_base[s];
          return;
        end
        seg_base[s][seg_cnt[s]] = open_base[s];
        seg_cnt[s] = seg_cnt[s] + 1'b1;
      end
      start_segment(s, 1'b1);
      return;
    end
    if (c == CH_DOT) begin
      if (dot_state[s] != DOTS_ORD) dot_state[s] = dot_state[s] + 1'b1;
    end else begin
      dot_state[s] = DOTS_ORD;
    end
    append_char(s, c);
    if (ovf_flag[s]) return;
    if (fin && (dot_state[s] == DOTS_ONE || dot_state[s] == DOTS_TWO)) begin
      path_len[s] = open_base[s];
      if (dot_state[s] == DOTS_TWO && slash_led[s]) drop_segment(s);
      if (slash_led[s]) append_char(s, CH_SLASH);
    end
  endfunction

  function automatic path_status_t normalize_step(int s, path_item_t it);
    path_status_t r;
    r.ch = 8'h00;
    if (it.cmd == CMD_READ) begin
      if (it.idx < path_len[s]) r.ch = path_mem[s][it.idx];
    end else if (!fin_flag[s]) begin
      if (!ovf_flag[s]) take_path_char(s, it.ch, it.last);
      if (it.last) fin_flag[s] = 1'b1;
    end
    if (path_len[s] > high_mark[s]) high_mark[s] = path_len[s];
    r.len = path_len[s];
    r.fin = fin_flag[s];
    r.ovf = ovf_flag[s];
    return r;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic idle_phase_t idle_phase();
    return idle_phase_t'((n_in / 120) % 4);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got 0x%0h want 0x%0h", n_out, what, got, want);
    n_errors++;
  endtask

  task automatic queue_item(logic c, logic [7:0] ch, logic l, logic [8:0] idx);
    path_item_t it;
    it.cmd = c;
    it.ch = ch;
    it.last = l;
    it.idx = idx;
    if (c == CMD_READ || (!fin_flag[PLAN] && !ovf_flag[PLAN])) n_planned++;
    path_items.push_back(it);
    void'(normalize_step(PLAN, it));
  endtask

  task automatic queue_char(logic [7:0] ch, logic l);
    queue_item(CMD_FEED, ch, l, 9'($urandom_range(511, 0)));
  endtask

  task automatic queue_read();
    int hw;
    int len;
    int lo;
    int hi;
    hw = high_mark[PLAN];
    len = path_len[PLAN];
    if (hw == 0) return;
    if (roll(75)) begin
      lo = 0;
      hi = hw - 1;
    end else begin
      lo = (len > 0) ? len - 1 : 0;
      hi = (len + 1 < hw - 1) ? len + 1 : hw - 1;
    end
    queue_item(CMD_READ, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
               9'($urandom_range(hi, lo)));
  endtask

  task automatic queue_text(string t);
    for (int i = 0; i < t.len(); i++) begin
      queue_char(t[i], 1'b0);
      if (roll(10)) queue_read();
    end
  endtask

  // any byte but a slash; dots show up often so names carry them
  function automatic logic [7:0] name_char();
    if (roll(25)) return CH_DOT;
    return 8'(CH_SLASH + 1 + $urandom_range(254, 0));
  endfunction

  task automatic queue_segment(seg_kind_t kind);
    int n;
    queue_char(CH_SLASH, 1'b0);
    case (kind)
      SEG_DOT: queue_char(CH_DOT, 1'b0);
      SEG_DOTDOT: begin
        queue_char(CH_DOT, 1'b0);
        queue_char(CH_DOT, 1'b0);
      end
      SEG_WORD: begin
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) queue_char(name_char(), 1'b0);
      end
      default: ;
    endcase
  endtask

  task automatic plan_random_path();
    int r;
    seg_kind_t kind;
    while (n_planned < 1150) begin
      r = $urandom_range(99, 0);
      if (r < 25) begin
        repeat ($urandom_range(3, 1)) queue_read();
      end else if (r < 28) begin
        queue_char(8'($urandom_range(255, 0)), 1'b0);
      end else begin
        r = $urandom_range(99, 0);
        if (path_len[PLAN] > 420 || seg_cnt[PLAN] > 200) begin
          kind = (r < 70) ? SEG_DOTDOT : SEG_WORD;
        end else begin
          kind = (r < 8) ? SEG_DOTDOT : (r < 16) ? SEG_DOT : (r < 24) ? SEG_EMPTY : SEG_WORD;
        end
        queue_segment(kind);
      end
    end
  endtask

  task automatic plan_ending();
    end_kind_t kind;
    logic [7:0] c;
    kind = end_kind_t'($urandom_range(2, 0));
    case (kind)
      END_DOT: begin
        queue_char(CH_SLASH, 1'b0);
        if (roll(50)) queue_char(CH_DOT, 1'b0);
        queue_char(CH_DOT, 1'b1);
      end
      END_STORE_FULL: begin
        while (!ovf_flag[PLAN]) begin
          c = name_char();
          queue_char((c == CH_DOT) ? 8'h61 : c, 1'b0);
          if (roll(5)) queue_read();
        end
        repeat (3) queue_char(8'($urandom_range(255, 0)), 1'b0);
        queue_char(8'($urandom_range(255, 0)), 1'b1);
      end
      default: begin
        while (!ovf_flag[PLAN]) begin
          queue_char(CH_SLASH, 1'b0);
          if (roll(5)) queue_read();
        end
        queue_char(8'($urandom_range(255, 0)), 1'b1);
      end
    endcase
  endtask

  // driver: present the next planned item at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || moved) begin
      moved = 1'b0;
      if (path_items.size() != 0 &&
          !roll((idle_phase() == PH_SEND_IDLE) ? 72 : (idle_phase() == PH_BOTH) ? 37 : 0)) begin
        in_valid   <= 1'b1;
        cmd        <= path_items[0].cmd;
        char_in    <= path_items[0].ch;
        last       <= path_items[0].last;
        read_index <= path_items[0].idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      fed_item.cmd  = cmd;
      fed_item.ch   = char_in;
      fed_item.last = last;
      fed_item.idx  = read_index;
      expected_status.push_back(normalize_step(LIVE, fed_item));
      void'(path_items.pop_front());
      n_in++;
      moved = 1'b1;
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_rx &&
                 !roll((idle_phase() == PH_RECV_STALL) ? 72 : (idle_phase() == PH_BOTH) ? 37 : 0);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("transfer with nothing expected", 0, 0);
      end else begin
        want_status = expected_status.pop_front();
        if (out_char !== want_status.ch) report_mismatch("out_char", out_char, want_status.ch);
        if (out_length !== want_status.len)
          report_mismatch("out_length", out_length, want_status.len);
        if (finished !== want_status.fin)
          report_mismatch("finished", finished, want_status.fin);
        if (overflowed !== want_status.ovf)
          report_mismatch("overflowed", overflowed, want_status.ovf);
      end
      n_out++;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (n_in >= 250);
    @(negedge clk);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    @(negedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      path_len[s]  = 10'd0;
      seg_cnt[s]   = 9'd0;
      open_base[s] = 10'd0;
      dot_state[s] = DOTS_NONE;
      slash_led[s] = 1'b0;
      fin_flag[s]  = 1'b0;
      ovf_flag[s]  = 1'b0;
      high_mark[s] = 0;
    end

    // leading "../", dots inside a name, "./" and "../" segments, NUL and 0xFF,
    // then more "../" than segments on the stack
    queue_text("../a.b/./../");
    queue_read();
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_read();
    queue_text("/../../");

    plan_random_path();
    plan_ending();

    // past the end: path characters are dropped, reads still answer
    repeat (90) begin
      if (roll(70)) queue_read();
      else queue_char(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (path_items.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
